>>> hw/rtl/swr_pkg.sv
// swr_pkg: shared types and codes of the stop-and-wait receiver
// item and result words, front-to-back commands; no dependencies
package swr_pkg;

	localparam int CNT_W = 6;

	localparam logic [2:0] PT_DATA      = 3'd0;
	localparam logic [2:0] PT_LAST_DATA = 3'd1;
	localparam logic [2:0] PT_ACK       = 3'd2;
	localparam logic [2:0] PT_NACK      = 3'd3;
	localparam logic [2:0] PT_TERMINATE = 3'd4;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_END  = 1'b1;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_REPLY  = 2'd1,
		KIND_PEER   = 2'd2,
		KIND_CLOSED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_RELEASE = 2'd0,
		OP_NACK    = 2'd1,
		OP_PEER    = 2'd2,
		OP_CLOSE   = 2'd3
	} op_t;

	typedef struct packed {
		logic               func;
		logic signed [7:0]  data_byte;
		logic [2:0]         packet_type;
		logic signed [31:0] packet_checksum;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic signed [7:0] out_byte;
		logic              reply_ack;
		logic              message_done;
		logic              last;
	} result_t;

	// command from front to back
	typedef struct packed {
		op_t              op;
		logic [CNT_W-1:0] count;
		logic             ack;
		logic             done;
	} cmd_t;

endpackage

>>> hw/rtl/swr_ram.sv
// swr_ram: generic single-write, single-read ram with registered read
// no dependencies
module swr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/swr_front.sv
// swr_front: accepts item words, buffers payload, keeps the checksum
// and classifies end words into commands; uses swr_pkg
module swr_front #(
	parameter int MAX_PAYLOAD = 32,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  swr_pkg::item_t item,
	output logic           push,
	output swr_pkg::cmd_t  push_cmd,
	input  logic           q_full,
	input  logic           rel_done,
	output logic           ram_we,
	output logic [AW-1:0]  ram_waddr,
	output logic [7:0]     ram_wdata
);
	import swr_pkg::*;

	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        sum_q;
	logic               ovf_q;
	logic               closed_q;
	logic [1:0]         rel_cnt_q;
	logic               accept;
	logic               room;
	logic [CNT_W-1:0]   cnt_inc;
	logic signed [14:0] prod;
	logic               type_data;
	logic               good;
	logic               rel_push;

	assign room      = cnt_q < CNT_W'(MAX_PAYLOAD);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign prod      = $signed({1'b0, cnt_inc}) * $signed(item.data_byte);
	assign type_data = (item.packet_type == PT_DATA) || (item.packet_type == PT_LAST_DATA);
	assign good      = !ovf_q && (sum_q == item.packet_checksum);

	// bytes wait while an earlier packet still has to be read out of the buffer
	always_comb begin
		if (closed_q) begin
			item_stall = 1'b0;
		end else if (item.func == FUNC_BYTE) begin
			item_stall = rel_cnt_q != 2'd0;
		end else begin
			item_stall = q_full;
		end
	end

	assign accept = item_valid && !item_stall;

	always_comb begin
		push_cmd.op    = OP_NACK;
		push_cmd.count = cnt_q;
		push_cmd.ack   = 1'b0;
		push_cmd.done  = 1'b0;
		push           = 1'b0;
		if (accept && !closed_q && item.func == FUNC_END) begin
			priority if (type_data) begin
				push           = 1'b1;
				push_cmd.op    = good ? OP_RELEASE : OP_NACK;
				push_cmd.done  = item.packet_type == PT_LAST_DATA;
			end else if (item.packet_type == PT_ACK || item.packet_type == PT_NACK) begin
				push           = 1'b1;
				push_cmd.op    = OP_PEER;
				push_cmd.ack   = item.packet_type == PT_ACK;
			end else if (item.packet_type == PT_TERMINATE) begin
				push           = 1'b1;
				push_cmd.op    = OP_CLOSE;
			end else begin
				push           = 1'b0;
			end
		end
	end

	// an empty release reads nothing back, so it never holds off bytes
	assign rel_push  = push && push_cmd.op == OP_RELEASE && push_cmd.count != '0;
	assign ram_we    = accept && !closed_q && item.func == FUNC_BYTE && room;
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_wdata = item.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
			closed_q  <= 1'b0;
			rel_cnt_q <= '0;
		end else begin
			rel_cnt_q <= rel_cnt_q + {1'b0, rel_push} - {1'b0, rel_done};
			if (accept && !closed_q) begin
				if (item.func == FUNC_BYTE) begin
					if (room) begin
						cnt_q <= cnt_inc;
						sum_q <= sum_q + 32'(prod);
					end else begin
						ovf_q <= 1'b1;
					end
				end else begin
					cnt_q <= '0;
					sum_q <= '0;
					ovf_q <= 1'b0;
					if (item.packet_type == PT_TERMINATE) begin
						closed_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/swr_queue.sv
// swr_queue: two-entry command queue between front and back
// uses swr_pkg for the command type
module swr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  swr_pkg::cmd_t push_cmd,
	output logic          full,
	output logic          not_empty,
	input  logic          pop,
	output swr_pkg::cmd_t head
);
	import swr_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign head      = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

>>> hw/rtl/swr_back.sv
// swr_back: carries out commands, drains released bytes from the buffer
// and drives the result register; uses swr_pkg
module swr_back #(
	parameter int MAX_PAYLOAD = 32,
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_not_empty,
	input  swr_pkg::cmd_t    q_head,
	output logic             pop,
	output logic             rel_done,
	output logic             ram_re,
	output logic [AW-1:0]    ram_raddr,
	input  logic [7:0]       ram_rdata,
	output logic             result_valid,
	input  logic             result_stall,
	output swr_pkg::result_t result
);
	import swr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EMIT  = 3'b010,
		ST_REPLY = 3'b100
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_nxt;
	logic             out_valid_q;
	result_t          out_q;
	logic             free;
	logic             load;
	result_t          load_word;
	logic             end_byte;

	assign free     = !out_valid_q || !result_stall;
	assign idx_nxt  = idx_q + CNT_W'(1);
	assign end_byte = idx_nxt == cmd_q.count;
	assign pop      = state_q == ST_IDLE && q_not_empty;
	assign load     = free && (state_q == ST_EMIT || state_q == ST_REPLY);
	assign rel_done = free && state_q == ST_EMIT && end_byte;

	// first read goes out while taking a release, next ones as each byte leaves
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (pop && q_head.op == OP_RELEASE && q_head.count != '0) begin
			ram_re = 1'b1;
		end else if (free && state_q == ST_EMIT && !end_byte) begin
			ram_re    = 1'b1;
			ram_raddr = idx_nxt[AW-1:0];
		end
	end

	always_comb begin
		load_word.kind         = KIND_REPLY;
		load_word.out_byte     = '0;
		load_word.reply_ack    = 1'b0;
		load_word.message_done = 1'b0;
		load_word.last         = 1'b1;
		if (state_q == ST_EMIT) begin
			load_word.kind     = KIND_BYTE;
			load_word.out_byte = ram_rdata;
			load_word.last     = 1'b0;
		end else begin
			unique case (cmd_q.op)
				OP_RELEASE: begin
					load_word.reply_ack    = 1'b1;
					load_word.message_done = cmd_q.done;
				end
				OP_NACK: begin
					load_word.reply_ack = 1'b0;
				end
				OP_PEER: begin
					load_word.kind      = KIND_PEER;
					load_word.reply_ack = cmd_q.ack;
				end
				OP_CLOSE: begin
					load_word.kind = KIND_CLOSED;
				end
				default: begin
					load_word.kind = KIND_REPLY;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
		end
		if (load) begin
			out_q <= load_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						idx_q <= '0;
						if (q_head.op == OP_RELEASE && q_head.count != '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_REPLY;
						end
					end
				end
				ST_EMIT: begin
					if (free) begin
						idx_q <= idx_nxt;
						if (end_byte) begin
							state_q <= ST_REPLY;
						end
					end
				end
				ST_REPLY: begin
					if (free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_emit_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> cmd_q.op == OP_RELEASE)
		else $error("byte drain without a release command");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> idx_q < cmd_q.count)
		else $error("drain index past buffered byte count");

	a_byte_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_EMIT) |=> !out_q.last && out_q.kind == KIND_BYTE)
		else $error("payload byte word marked last");

	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == ST_REPLY) |=> out_q.last && state_q == ST_IDLE)
		else $error("reply word not marked last");

endmodule

>>> hw/rtl/stop_and_wait_receiver.sv
// Receiving end of a stop-and-wait link. A payload byte goes into a MAX_PAYLOAD-byte
// buffer while the position-weighted checksum is updated. An end word is classified
// and queued; its result word passes the queue entry, the back's command register
// and the result register. A good data packet drains out of the buffer at one byte
// per cycle while the result is not stalled, and its ACK reply word follows. The
// buffer has one write port, used by the front, and one read port, used by the
// back; bytes of the next packet are held off until the previous packet's bytes
// have been read out. After a terminate packet all later words are taken and dropped.
// Top level: instantiates swr_front, swr_queue, swr_back and swr_ram; uses swr_pkg.
module stop_and_wait_receiver #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  swr_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output swr_pkg::result_t result
);
	import swr_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic          push;
	cmd_t          push_cmd;
	logic          q_full;
	logic          q_not_empty;
	logic          pop;
	cmd_t          q_head;
	logic          rel_done;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	swr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full),
		.rel_done  (rel_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	swr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.not_empty(q_not_empty),
		.pop      (pop),
		.head     (q_head)
	);

	swr_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	swr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.rel_done    (rel_done),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
